@@ src/tcrq_pkg.sv @@
// ---------------------------------------------------------------------------
// tcrq_pkg
// shared types and constants for the timestamped command release queue
// ---------------------------------------------------------------------------
package tcrq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TIME_BITS    = 48;
  localparam int PAYLOAD_BITS = 64;
  localparam int DELAY_BITS   = 21;
  localparam int LEAD_BITS    = TIME_BITS + 1;
  localparam int EXT_BITS     = TIME_BITS + 2;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BUFFERING_ENABLE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTUATOR_DELAY   = 1'd1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  // row-wide command to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } tcrq_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POLL,
    ST_DONE
  } tcrq_state_t;

endpackage

@@ src/tcrq_cell.sv @@
// ---------------------------------------------------------------------------
// tcrq_cell
// one slot of the sorted queue: shifts right on insert, left on release
// ---------------------------------------------------------------------------
module tcrq_cell
  import tcrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tcrq_ctl_t ctl,
  input  time_t     new_stamp,
  input  payload_t  new_payload,
  input  logic      left_valid,
  input  logic      left_after,
  input  time_t     left_stamp,
  input  payload_t  left_payload,
  input  logic      right_valid,
  input  time_t     right_stamp,
  input  payload_t  right_payload,
  output logic      valid_o,
  output logic      after_o,
  output time_t     stamp_o,
  output payload_t  payload_o
);

  logic     valid_r, valid_nxt;
  time_t    stamp_r, stamp_nxt;
  payload_t payload_r, payload_nxt;

  // empty, or strictly later than the new stamp: this slot moves right
  assign after_o   = !valid_r || (stamp_r > new_stamp);
  assign valid_o   = valid_r;
  assign stamp_o   = stamp_r;
  assign payload_o = payload_r;

  always_comb begin
    valid_nxt   = valid_r;
    stamp_nxt   = stamp_r;
    payload_nxt = payload_r;
    if (ctl.pop) begin
      valid_nxt   = right_valid;
      stamp_nxt   = right_stamp;
      payload_nxt = right_payload;
    end else if (ctl.ins && after_o) begin
      if (!left_after) begin
        // first slot past the equal stamps takes the new item
        valid_nxt   = 1'b1;
        stamp_nxt   = new_stamp;
        payload_nxt = new_payload;
      end else begin
        valid_nxt   = left_valid;
        stamp_nxt   = left_stamp;
        payload_nxt = left_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r   <= stamp_nxt;
    payload_r <= payload_nxt;
  end

endmodule

@@ src/tcrq_chain.sv @@
// ---------------------------------------------------------------------------
// tcrq_chain
// row of queue cells, head at cell zero
// ---------------------------------------------------------------------------
module tcrq_chain
  import tcrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tcrq_ctl_t ctl,
  input  time_t     new_stamp,
  input  payload_t  new_payload,
  output logic      head_valid,
  output time_t     head_stamp,
  output payload_t  head_payload,
  output logic      full
);

  logic     valid_w   [QUEUE_DEPTH];
  logic     after_w   [QUEUE_DEPTH];
  time_t    stamp_w   [QUEUE_DEPTH];
  payload_t payload_w [QUEUE_DEPTH];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic     l_valid, l_after, r_valid;
    time_t    l_stamp, r_stamp;
    payload_t l_payload, r_payload;

    if (g == 0) begin : g_head
      assign l_valid   = 1'b0;
      assign l_after   = 1'b0;
      assign l_stamp   = '0;
      assign l_payload = '0;
    end else begin : g_mid
      assign l_valid   = valid_w[g-1];
      assign l_after   = after_w[g-1];
      assign l_stamp   = stamp_w[g-1];
      assign l_payload = payload_w[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid   = 1'b0;
      assign r_stamp   = '0;
      assign r_payload = '0;
    end else begin : g_body
      assign r_valid   = valid_w[g+1];
      assign r_stamp   = stamp_w[g+1];
      assign r_payload = payload_w[g+1];
    end

    tcrq_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .new_stamp     (new_stamp),
      .new_payload   (new_payload),
      .left_valid    (l_valid),
      .left_after    (l_after),
      .left_stamp    (l_stamp),
      .left_payload  (l_payload),
      .right_valid   (r_valid),
      .right_stamp   (r_stamp),
      .right_payload (r_payload),
      .valid_o       (valid_w[g]),
      .after_o       (after_w[g]),
      .stamp_o       (stamp_w[g]),
      .payload_o     (payload_w[g])
    );
  end

  assign head_valid   = valid_w[0];
  assign head_stamp   = stamp_w[0];
  assign head_payload = payload_w[0];
  assign full         = valid_w[QUEUE_DEPTH-1];

endmodule

@@ src/timestamped_command_release_queue.sv @@
// ---------------------------------------------------------------------------
// timestamped_command_release_queue
// stamp-sorted command queue that releases due entries on poll
// ---------------------------------------------------------------------------
// push: inserted in the acceptance cycle, result then loaded from the DONE state
// poll: one entry leaves the head of the cell row per cycle while due entries
//   remain (up to 16), then the result is loaded from the DONE state
// next item is taken once the previous result sits in the output register
// reset: queue empty, last command time 0, buffering on, delay 0
module timestamped_command_release_queue
  import tcrq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [DELAY_BITS-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  time_t                         in_now_time,
  input  time_t                         in_command_stamp,
  input  payload_t                      in_command_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_stored,
  output logic                          out_dropped_full,
  output logic signed [LEAD_BITS-1:0]   out_stamp_lead,
  output logic                          out_found,
  output payload_t                      out_action_payload,
  output time_t                         out_last_command_time
);

  localparam time_t TIME_MAX = '1;

  tcrq_state_t state_r, state_nxt;

  logic                  enable_r;
  logic [DELAY_BITS-1:0] delay_r;
  time_t                 now_r, now_nxt;
  time_t                 last_apply_r, last_apply_nxt;

  logic                  res_stored_r, res_stored_nxt;
  logic                  res_dropped_r, res_dropped_nxt;
  logic [LEAD_BITS-1:0]  res_lead_r, res_lead_nxt;
  logic                  res_found_r, res_found_nxt;
  payload_t              res_payload_r, res_payload_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;

  tcrq_ctl_t             ctl;
  logic                  head_valid, full;
  time_t                 head_stamp;
  payload_t              head_payload;

  logic                  in_accept;
  logic                  stamp_future;
  logic [LEAD_BITS-1:0]  lead;
  logic signed [EXT_BITS-1:0] delay_ext, head_adj, now_ext, apply_sum;
  logic                  head_due;
  time_t                 apply_time;

  assign in_accept    = in_valid && !in_stall;
  assign in_stall     = (state_r != ST_IDLE);
  assign stamp_future = in_command_stamp > in_now_time;
  assign lead         = {1'b0, in_command_stamp} - {1'b0, in_now_time};

  // exact stamp - delay < now in a signed word two bits wider than time
  assign delay_ext = $signed({{(EXT_BITS-DELAY_BITS){delay_r[DELAY_BITS-1]}}, delay_r});
  assign now_ext   = $signed({2'b00, now_r});
  assign head_adj  = $signed({2'b00, head_stamp}) - delay_ext;
  assign head_due  = head_adj < now_ext;

  // now + delay, clamped to the time range
  assign apply_sum = now_ext + delay_ext;
  always_comb begin
    if (apply_sum[EXT_BITS-1]) begin
      apply_time = '0;
    end else if (apply_sum > $signed({2'b00, TIME_MAX})) begin
      apply_time = TIME_MAX;
    end else begin
      apply_time = apply_sum[TIME_BITS-1:0];
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt       = state_r;
    now_nxt         = now_r;
    last_apply_nxt  = last_apply_r;
    res_stored_nxt  = res_stored_r;
    res_dropped_nxt = res_dropped_r;
    res_lead_nxt    = res_lead_r;
    res_found_nxt   = res_found_r;
    res_payload_nxt = res_payload_r;
    out_valid_nxt   = out_valid_r;
    ctl             = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          now_nxt         = in_now_time;
          res_stored_nxt  = 1'b0;
          res_dropped_nxt = 1'b0;
          res_lead_nxt    = '0;
          res_found_nxt   = 1'b0;
          res_payload_nxt = '0;
          if (in_func == FUNC_POLL) begin
            state_nxt = ST_POLL;
          end else begin
            state_nxt = ST_DONE;
            if (enable_r) begin
              res_lead_nxt = lead;
              if (stamp_future) begin
                if (full) begin
                  res_dropped_nxt = 1'b1;
                end else begin
                  ctl.ins        = 1'b1;
                  res_stored_nxt = 1'b1;
                end
              end
            end
          end
        end
      end
      ST_POLL: begin
        if (head_valid && head_due) begin
          ctl.pop         = 1'b1;
          res_found_nxt   = 1'b1;
          res_payload_nxt = head_payload;
        end else begin
          if (res_found_r) begin
            last_apply_nxt = apply_time;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  tcrq_chain u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .new_stamp    (in_command_stamp),
    .new_payload  (in_command_payload),
    .head_valid   (head_valid),
    .head_stamp   (head_stamp),
    .head_payload (head_payload),
    .full         (full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      last_apply_r <= '0;
      enable_r     <= 1'b1;
      delay_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      last_apply_r <= last_apply_nxt;
      if (cfg_we && (cfg_index == CFG_BUFFERING_ENABLE)) begin
        enable_r <= cfg_wdata[0];
      end
      if (cfg_we && (cfg_index == CFG_ACTUATOR_DELAY)) begin
        delay_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    res_stored_r  <= res_stored_nxt;
    res_dropped_r <= res_dropped_nxt;
    res_lead_r    <= res_lead_nxt;
    res_found_r   <= res_found_nxt;
    res_payload_r <= res_payload_nxt;
    if (out_load) begin
      out_stored            <= res_stored_r;
      out_dropped_full      <= res_dropped_r;
      out_stamp_lead        <= $signed(res_lead_r);
      out_found             <= res_found_r;
      out_action_payload    <= res_payload_r;
      out_last_command_time <= last_apply_r;
    end
  end

  assign out_valid = out_valid_r;

  // releasing from an empty row would invent an entry
  assert property (@(posedge clk) disable iff (!rst_n) ctl.pop |-> head_valid)
    else $error("release from empty queue");

  // an insert into a full row would lose the tail entry
  assert property (@(posedge clk) disable iff (!rst_n) ctl.ins |-> !full)
    else $error("insert into full queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (!out_stored && !out_dropped_full && out_stamp_lead == 0))
    else $error("poll item carries push fields");

  // a release never coincides with a new item being taken
  assert property (@(posedge clk) disable iff (!rst_n) ctl.pop |-> !in_accept)
    else $error("item taken during release");

endmodule

@@ verif/timestamped_command_release_queue_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timestamped_command_release_queue_tb
// pushes and polls stamped commands with random gaps and stalls on both
// sides, predicts every result from a copy of the queue state and checks
// each result field by field in arrival order
// ---------------------------------------------------------------------------
module timestamped_command_release_queue_tb;
  import tcrq_pkg::*;

  localparam time_t TIME_MAX = '1;
  localparam logic signed [DELAY_BITS-1:0] DELAY_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [DELAY_BITS-1:0] DELAY_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};
  localparam int DRAIN_SLACK     = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 185;

  typedef struct packed {
    logic                 stored;
    logic                 dropped_full;
    logic [LEAD_BITS-1:0] stamp_lead;
    logic                 found;
    payload_t             action_payload;
    time_t                last_command_time;
  } release_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CFG_IDX_BITS-1:0]     cfg_index;
  logic [DELAY_BITS-1:0]       cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_func;
  time_t                       in_now_time;
  time_t                       in_command_stamp;
  payload_t                    in_command_payload;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_stored;
  logic                        out_dropped_full;
  logic signed [LEAD_BITS-1:0] out_stamp_lead;
  logic                        out_found;
  payload_t                    out_action_payload;
  time_t                       out_last_command_time;

  // shadow of the queue and its registers
  time_t                        shadow_stamps[QUEUE_DEPTH];
  payload_t                     shadow_payloads[QUEUE_DEPTH];
  int                           shadow_count;
  time_t                        shadow_last_apply;
  logic                         shadow_buffering;
  logic signed [DELAY_BITS-1:0] shadow_delay;

  release_result_t pending_results[$];
  int              error_count = 0;
  int              idle_pct;
  int              stall_hold;

  timestamped_command_release_queue DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_now_time          (in_now_time),
    .in_command_stamp     (in_command_stamp),
    .in_command_payload   (in_command_payload),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_stored           (out_stored),
    .out_dropped_full     (out_dropped_full),
    .out_stamp_lead       (out_stamp_lead),
    .out_found            (out_found),
    .out_action_payload   (out_action_payload),
    .out_last_command_time(out_last_command_time)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic time_t any_time();
    return time_t'({$urandom, $urandom});
  endfunction

  function automatic payload_t any_payload();
    return {$urandom, $urandom};
  endfunction

  function automatic time_t clamp_time(input longint v);
    if (v < 0) return '0;
    if (v > longint'(TIME_MAX)) return TIME_MAX;
    return time_t'(v);
  endfunction

  // works out the result of one item and updates the shadow queue
  function automatic release_result_t compute_queue_result(input logic func, input time_t now,
                                                           input time_t stamp,
                                                           input payload_t payload);
    release_result_t r;
    int              pos;
    int              k;
    longint          now_l;
    longint          dly;
    r     = '0;
    now_l = now;
    dly   = shadow_delay;
    if (func == FUNC_PUSH) begin
      if (shadow_buffering) begin
        r.stamp_lead = {1'b0, stamp} - {1'b0, now};
        if (stamp > now) begin
          if (shadow_count < QUEUE_DEPTH) begin
            pos = 0;
            // a new command goes behind any of equal stamp
            while (pos < shadow_count && shadow_stamps[pos] <= stamp) pos++;
            for (int i = shadow_count; i > pos; i--) begin
              shadow_stamps[i]   = shadow_stamps[i-1];
              shadow_payloads[i] = shadow_payloads[i-1];
            end
            shadow_stamps[pos]   = stamp;
            shadow_payloads[pos] = payload;
            shadow_count++;
            r.stored = 1'b1;
          end else begin
            r.dropped_full = 1'b1;
          end
        end
      end
    end else begin
      k = 0;
      while (k < shadow_count && longint'(shadow_stamps[k]) - dly < now_l) k++;
      if (k > 0) begin
        r.found           = 1'b1;
        r.action_payload  = shadow_payloads[k-1];
        shadow_last_apply = clamp_time(now_l + dly);
        for (int i = 0; i < shadow_count - k; i++) begin
          shadow_stamps[i]   = shadow_stamps[i+k];
          shadow_payloads[i] = shadow_payloads[i+k];
        end
        shadow_count -= k;
      end
    end
    r.last_command_time = shadow_last_apply;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic func, input time_t now, input time_t stamp,
                           input payload_t payload);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_func            = func;
    in_now_time        = now;
    in_command_stamp   = stamp;
    in_command_payload = payload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(),
                           compute_queue_result(func, now, stamp, payload));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                           input logic [DELAY_BITS-1:0] data);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (index == CFG_BUFFERING_ENABLE) shadow_buffering = data[0];
    else shadow_delay = data;
  endtask

  // stamps a little ahead of a moving clock, polls advance it
  task automatic send_traffic_item(inout time_t clock_us, input int push_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_item(1'($urandom_range(1)), any_time(), any_time(), any_payload());
    end else if ($urandom_range(99) < push_pct) begin
      send_item(FUNC_PUSH, clock_us,
                clamp_time(longint'(clock_us) + int'($urandom_range(600)) - 60), any_payload());
    end else begin
      clock_us = clamp_time(longint'(clock_us) + int'($urandom_range(120)));
      send_item(FUNC_POLL, clock_us, any_time(), any_payload());
    end
  endtask

  task automatic test_directed();
    // extreme leads of both signs, and a stamp equal to now
    send_item(FUNC_PUSH, '0, TIME_MAX, '1);
    send_item(FUNC_PUSH, TIME_MAX, '0, '0);
    send_item(FUNC_PUSH, 48'd1000, 48'd1000, any_payload());
    // equal stamps keep arrival order, earlier stamp goes in front
    send_item(FUNC_PUSH, 48'd100, 48'd500, 64'hA5A5_A5A5_A5A5_A5A5);
    send_item(FUNC_PUSH, 48'd120, 48'd500, 64'h5A5A_5A5A_5A5A_5A5A);
    send_item(FUNC_PUSH, 48'd130, 48'd300, 64'h0123_4567_89AB_CDEF);
    send_item(FUNC_POLL, 48'd300, '0, '0);
    send_item(FUNC_POLL, 48'd301, any_time(), any_payload());
    send_item(FUNC_POLL, 48'd501, any_time(), any_payload());
    // pushes ignored while disabled, polls still release
    write_reg(CFG_BUFFERING_ENABLE, '0);
    send_item(FUNC_PUSH, '0, 48'd10, any_payload());
    write_reg(CFG_ACTUATOR_DELAY, DELAY_MAX);
    send_item(FUNC_POLL, TIME_MAX - 48'd1048575, any_time(), any_payload());
    send_item(FUNC_POLL, TIME_MAX - 48'd1048574, any_time(), any_payload());
    // most negative delay: release only once stamp minus delay lies behind now
    write_reg(CFG_BUFFERING_ENABLE, {{(DELAY_BITS-1){1'b0}}, 1'b1});
    write_reg(CFG_ACTUATOR_DELAY, DELAY_MIN);
    send_item(FUNC_PUSH, 48'd5, 48'd6, '0);
    send_item(FUNC_POLL, 48'd1048582, any_time(), any_payload());
    send_item(FUNC_POLL, 48'd1048583, any_time(), any_payload());
    send_item(FUNC_POLL, 48'd3, any_time(), any_payload());
    write_reg(CFG_ACTUATOR_DELAY, '0);
  endtask

  task automatic test_full_queue();
    time_t base;
    base = 48'd50000 + time_t'($urandom_range(10000));
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_item(FUNC_PUSH, base, base + 1 + time_t'($urandom_range(200)), any_payload());
    send_item(FUNC_PUSH, base, base + 48'd7, any_payload());
    // a stamp not in the future is no drop even when full
    send_item(FUNC_PUSH, base, base, any_payload());
    send_item(FUNC_POLL, base + 48'd100, any_time(), any_payload());
    send_item(FUNC_POLL, base + 48'd1000, any_time(), any_payload());
  endtask

  task automatic test_backpressure();
    time_t clock_us;
    clock_us   = 48'd2000000;
    // receiver holds off while items keep coming
    stall_hold = 400;
    repeat (40) send_traffic_item(clock_us, 60);
    wait_drained();
    repeat (20) send_traffic_item(clock_us, 60);
  endtask

  task automatic test_random_traffic();
    time_t clock_us;
    int    push_pct;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_BUFFERING_ENABLE, {20'($urandom), (p != 3)});
      case (p)
        1: write_reg(CFG_ACTUATOR_DELAY, DELAY_MAX);
        2: write_reg(CFG_ACTUATOR_DELAY, DELAY_MIN);
        6: write_reg(CFG_ACTUATOR_DELAY, 21'($urandom));
        default: write_reg(CFG_ACTUATOR_DELAY, 21'($urandom_range(600) - 300));
      endcase
      case (p % 3)
        0: clock_us = time_t'($urandom_range(50));
        1: clock_us = any_time() >> 1;
        default: clock_us = TIME_MAX - 48'd30000;
      endcase
      idle_pct = (p == 5) ? 0 : 19;
      push_pct = 40 + $urandom_range(30);
      repeat (ITEMS_PER_PHASE) send_traffic_item(clock_us, push_pct);
      // flush whatever is due at the end of time
      send_item(FUNC_POLL, TIME_MAX, any_time(), any_payload());
    end
    idle_pct = 19;
  endtask

  // receiver side: random stalls, or a long hold when asked
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall  = 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall = ($urandom_range(99) < idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [PAYLOAD_BITS-1:0] want,
                             input logic [PAYLOAD_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    release_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        error_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("stored", want.stored, out_stored);
        check_field("dropped_full", want.dropped_full, out_dropped_full);
        check_field("stamp_lead", want.stamp_lead, $unsigned(out_stamp_lead));
        check_field("found", want.found, out_found);
        check_field("action_payload", want.action_payload, out_action_payload);
        check_field("last_command_time", want.last_command_time, out_last_command_time);
      end
    end
  end

  initial begin
    int guard;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_BUFFERING_ENABLE;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_func            = FUNC_PUSH;
    in_now_time        = '0;
    in_command_stamp   = '0;
    in_command_payload = '0;
    out_stall          = 1'b0;
    idle_pct           = 19;
    stall_hold         = 0;
    shadow_count       = 0;
    shadow_last_apply  = '0;
    shadow_buffering   = 1'b1;
    shadow_delay       = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_queue();
    test_backpressure();
    test_random_traffic();

    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_SLACK) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $error("simulation timed out");
    $display("Test completed with failures");
    $finish;
  end

endmodule
